// ===== src/smdv_pkg.sv =====
// Shared types, codes and sizes for the segment mean and diagonal variance block.
package smdv_pkg;

  // Fixed field widths of the item and result beats
  localparam int VALUE_W = 16;
  localparam int DIM_W   = 6;
  localparam int MEAN_W  = 16;
  localparam int VAR_W   = 31;

  // Parameter defaults
  localparam int DIMS_DEF       = 39;
  localparam int MAX_FRAMES_DEF = 1024;

  // Saturation limits
  localparam longint MEAN_MAX     = 32767;
  localparam longint MEAN_NEG_MAG = 32768;
  localparam longint VAR_MAX      = 64'h7FFF_FFFF;

  // Command codes
  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_REPORT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [DIM_W-1:0]         dimension;
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic                     empty_res;
    logic                     dropped;
    logic                     last;
  } out_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } alu_sts_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

endpackage

// ===== src/segment_mean_diag_variance_top.sv =====
// Top level: command sequencer for the segment mean and diagonal variance block.
//
// Usage: drive in_i and raise start_i; the command is taken at a clock edge with
// start_i high and busy_o low. Commands: push one element of the current frame,
// report, or clear the segment.
// A push raises busy_o after the accept: the element is squared on the shared
// shift-add unit, one multiplier bit per cycle, then added into the per-dimension
// memory. A push into a full segment and a clear leave busy_o low.
// A report emits DIMS result beats, one per dimension, each on out_o for a single
// cycle with out_valid_o high; last marks the final dimension. Each dimension
// runs s1*s1, n*s2, the variance division (skipped, giving zero, when n*s2 - s1*s1
// is not positive) and the mean division on the same unit, one bit per cycle.
// An empty segment reports one beat per cycle.
// The receiver cannot stall; every beat must be taken in the cycle it is shown.
// Reset empties the segment: all sums, the frame count and the drop flag read as
// zero, and the block is ready right after reset is released.
module segment_mean_diag_variance_top #(
  parameter int DIMS       = smdv_pkg::DIMS_DEF,
  parameter int MAX_FRAMES = smdv_pkg::MAX_FRAMES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  smdv_pkg::in_t  in_i,
  output logic           busy_o,
  output logic           out_valid_o,
  output smdv_pkg::out_t out_o
);

  localparam int VALUE_W = smdv_pkg::VALUE_W;
  localparam int DIM_W   = smdv_pkg::DIM_W;
  localparam int MEAN_W  = smdv_pkg::MEAN_W;
  localparam int VAR_W   = smdv_pkg::VAR_W;
  localparam int AW      = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W   = VALUE_W + CNT_W;
  localparam int SQ_W    = 2 * VALUE_W - 2 + CNT_W;
  localparam int MW      = 2 * CNT_W + 2 * VALUE_W;
  localparam int CW      = $clog2(MW + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PSQ  = 9'b000000010,
    S_RNN  = 9'b000000100,
    S_RRD  = 9'b000001000,
    S_RS1  = 9'b000010000,
    S_RNS  = 9'b000100000,
    S_RVD  = 9'b001000000,
    S_RMD  = 9'b010000000,
    S_RZ   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic [CNT_W-1:0]          frame_cnt_q, frame_cnt_d;
  logic                      ovf_q, ovf_d;
  logic [AW-1:0]             d_q, d_d;
  logic signed [VALUE_W-1:0] v_q, v_d;
  logic [SUM_W-1:0]          abs_s1_q, abs_s1_d;
  logic                      s1_neg_q, s1_neg_d;
  logic [SQ_W-1:0]           s2_q, s2_d;
  logic [MW-1:0]             sq1_q, sq1_d;
  logic [2*CNT_W-1:0]        nn_q, nn_d;
  logic [VAR_W-1:0]          var_q, var_d;
  logic                      out_valid_q;
  smdv_pkg::out_t            out_q, out_d;
  logic                      emit;

  smdv_pkg::alu_ctl_t        alu_ctl;
  smdv_pkg::alu_sts_t        alu_sts;
  logic [MW-1:0]             alu_a, alu_b, alu_res;
  logic [CW-1:0]             alu_steps;

  smdv_pkg::mem_ctl_t        mem_ctl;
  logic [AW-1:0]             mem_rd_addr;
  logic signed [SUM_W-1:0]   mem_rd_sum, mem_wr_sum;
  logic [SQ_W-1:0]           mem_rd_sq, mem_wr_sq;

  logic                      full;
  logic                      pos_wrap;
  logic [AW-1:0]             pos_inc;
  logic                      d_last;
  logic [VALUE_W:0]          val_ext, abs_in;
  logic [SUM_W-1:0]          abs_rd;
  logic [MW-1:0]             n_ext;
  logic [MW-1:0]             mean_dvd;
  logic                      num_pos;
  logic [MW-1:0]             num;
  logic [SUM_W-1:0]          quo;
  logic [SUM_W:0]            mag;
  logic [SUM_W:0]            neg_full;
  logic [MEAN_W-1:0]         mean_val;
  logic [VAR_W-1:0]          var_sat;

  // Shared multiply and divide unit
  smdv_alu #(
    .W (MW)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (alu_ctl),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .steps_i (alu_steps),
    .res_o   (alu_res),
    .sts_o   (alu_sts)
  );

  // Per-dimension accumulators
  smdv_store #(
    .DIMS  (DIMS),
    .AW    (AW),
    .SUM_W (SUM_W),
    .SQ_W  (SQ_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (mem_rd_addr),
    .wr_addr_i (pos_q),
    .wr_sum_i  (mem_wr_sum),
    .wr_sq_i   (mem_wr_sq),
    .rd_sum_o  (mem_rd_sum),
    .rd_sq_o   (mem_rd_sq)
  );

  // Position, count and operand helpers
  assign full     = (frame_cnt_q >= CNT_W'(MAX_FRAMES));
  assign pos_wrap = (pos_q == AW'(DIMS - 1));
  assign pos_inc  = pos_wrap ? '0 : pos_q + AW'(1);
  assign d_last   = (d_q == AW'(DIMS - 1));
  assign val_ext  = {in_i.value[VALUE_W-1], in_i.value};
  assign abs_in   = val_ext[VALUE_W] ? (VALUE_W+1)'(0) - val_ext : val_ext;
  assign abs_rd   = mem_rd_sum[SUM_W-1] ? SUM_W'(0) - SUM_W'(mem_rd_sum)
                                        : SUM_W'(mem_rd_sum);
  assign n_ext    = MW'(frame_cnt_q);
  assign mean_dvd = {abs_s1_q, {(MW-SUM_W){1'b0}}};
  assign num_pos  = (alu_res > sq1_q);
  assign num      = alu_res - sq1_q;

  // Accumulate: old sums plus the element and its square
  assign mem_wr_sum = mem_rd_sum + {{(SUM_W-VALUE_W){v_q[VALUE_W-1]}}, v_q};
  assign mem_wr_sq  = mem_rd_sq + alu_res[SQ_W-1:0];

  // Floor mean from quotient, remainder and sign, saturated to the field
  assign quo      = alu_res[SUM_W-1:0];
  assign mag      = {1'b0, quo} + {{SUM_W{1'b0}}, alu_sts.rem_nz};
  assign neg_full = (SUM_W+1)'(0) - mag;
  always_comb begin
    if (!s1_neg_q) begin
      mean_val = (quo > SUM_W'(smdv_pkg::MEAN_MAX)) ? MEAN_W'(smdv_pkg::MEAN_MAX)
                                                    : quo[MEAN_W-1:0];
    end else begin
      mean_val = (mag > (SUM_W+1)'(smdv_pkg::MEAN_NEG_MAG))
                 ? MEAN_W'(smdv_pkg::MEAN_NEG_MAG) : neg_full[MEAN_W-1:0];
    end
  end

  // Saturate the variance quotient
  assign var_sat = (alu_res > MW'(smdv_pkg::VAR_MAX)) ? VAR_W'(smdv_pkg::VAR_MAX)
                                                      : alu_res[VAR_W-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    frame_cnt_d = frame_cnt_q;
    ovf_d       = ovf_q;
    d_d         = d_q;
    v_d         = v_q;
    abs_s1_d    = abs_s1_q;
    s1_neg_d    = s1_neg_q;
    s2_d        = s2_q;
    sq1_d       = sq1_q;
    nn_d        = nn_q;
    var_d       = var_q;
    out_d       = out_q;
    emit        = 1'b0;
    alu_ctl     = '{start: 1'b0, op: smdv_pkg::ALU_MUL};
    alu_a       = '0;
    alu_b       = '0;
    alu_steps   = '0;
    mem_ctl     = '0;
    mem_rd_addr = d_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (in_i.mode)
            smdv_pkg::MODE_PUSH: begin
              if (full) begin
                // drop the element, keep the position moving
                ovf_d = 1'b1;
                pos_d = pos_inc;
              end else begin
                v_d           = in_i.value;
                mem_ctl.rd_en = 1'b1;
                mem_rd_addr   = pos_q;
                alu_ctl.start = 1'b1;
                alu_a         = MW'(abs_in);
                alu_b         = MW'(abs_in);
                alu_steps     = CW'(VALUE_W);
                state_d       = S_PSQ;
              end
            end
            smdv_pkg::MODE_REPORT: begin
              d_d = '0;
              if (frame_cnt_q == '0) begin
                state_d = S_RZ;
              end else begin
                alu_ctl.start = 1'b1;
                alu_a         = n_ext;
                alu_b         = n_ext;
                alu_steps     = CW'(CNT_W);
                state_d       = S_RNN;
              end
            end
            smdv_pkg::MODE_CLEAR: begin
              mem_ctl.clr = 1'b1;
              pos_d       = '0;
              frame_cnt_d = '0;
              ovf_d       = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_PSQ: begin
        if (alu_sts.done) begin
          mem_ctl.wr_en = 1'b1;
          pos_d         = pos_inc;
          if (pos_wrap) begin
            frame_cnt_d = frame_cnt_q + CNT_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      S_RNN: begin
        if (alu_sts.done) begin
          nn_d          = alu_res[2*CNT_W-1:0];
          mem_ctl.rd_en = 1'b1;
          state_d       = S_RRD;
        end
      end
      S_RRD: begin
        abs_s1_d      = abs_rd;
        s1_neg_d      = mem_rd_sum[SUM_W-1];
        s2_d          = mem_rd_sq;
        alu_ctl.start = 1'b1;
        alu_a         = MW'(abs_rd);
        alu_b         = MW'(abs_rd);
        alu_steps     = CW'(SUM_W);
        state_d       = S_RS1;
      end
      S_RS1: begin
        if (alu_sts.done) begin
          sq1_d         = alu_res;
          alu_ctl.start = 1'b1;
          alu_a         = MW'(s2_q);
          alu_b         = n_ext;
          alu_steps     = CW'(CNT_W);
          state_d       = S_RNS;
        end
      end
      S_RNS: begin
        if (alu_sts.done) begin
          alu_ctl.start = 1'b1;
          alu_ctl.op    = smdv_pkg::ALU_DIV;
          if (num_pos) begin
            alu_a     = num;
            alu_b     = MW'(nn_q);
            alu_steps = CW'(MW);
            state_d   = S_RVD;
          end else begin
            // no positive spread: variance is zero, go straight to the mean
            var_d     = '0;
            alu_a     = mean_dvd;
            alu_b     = n_ext;
            alu_steps = CW'(SUM_W);
            state_d   = S_RMD;
          end
        end
      end
      S_RVD: begin
        if (alu_sts.done) begin
          var_d         = var_sat;
          alu_ctl.start = 1'b1;
          alu_ctl.op    = smdv_pkg::ALU_DIV;
          alu_a         = mean_dvd;
          alu_b         = n_ext;
          alu_steps     = CW'(SUM_W);
          state_d       = S_RMD;
        end
      end
      S_RMD: begin
        if (alu_sts.done) begin
          emit            = 1'b1;
          out_d.dimension = DIM_W'(d_q);
          out_d.mean      = mean_val;
          out_d.variance  = var_q;
          out_d.empty_res = 1'b0;
          out_d.dropped   = ovf_q;
          out_d.last      = d_last;
          if (d_last) begin
            state_d = S_IDLE;
          end else begin
            d_d           = d_q + AW'(1);
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = d_q + AW'(1);
            state_d       = S_RRD;
          end
        end
      end
      S_RZ: begin
        // empty segment: one zero beat per dimension
        emit            = 1'b1;
        out_d.dimension = DIM_W'(d_q);
        out_d.mean      = '0;
        out_d.variance  = '0;
        out_d.empty_res = 1'b1;
        out_d.dropped   = ovf_q;
        out_d.last      = d_last;
        if (d_last) begin
          state_d = S_IDLE;
        end else begin
          d_d = d_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      frame_cnt_q <= '0;
      ovf_q       <= 1'b0;
      d_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      frame_cnt_q <= frame_cnt_d;
      ovf_q       <= ovf_d;
      d_q         <= d_d;
      out_valid_q <= emit;
    end
  end

  // Working registers and result beat
  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    abs_s1_q <= abs_s1_d;
    s1_neg_q <= s1_neg_d;
    s2_q     <= s2_d;
    sq1_q    <= sq1_d;
    nn_q     <= nn_d;
    var_q    <= var_d;
    out_q    <= out_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  // The final beat of a report leaves the block ready
  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.last |-> !busy_o)
    else $error("last report beat while still busy");

  // Every other report beat keeps the block busy
  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.last |-> busy_o)
    else $error("report run ended early");

  // Frame count stays within capacity
  a_cnt_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_cnt_q <= CNT_W'(MAX_FRAMES))
    else $error("frame count beyond capacity");

  // The shared unit only finishes work the sequencer is waiting on
  a_alu_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_sts.done |-> (state_q != S_IDLE && state_q != S_RRD && state_q != S_RZ))
    else $error("arithmetic unit finished outside a wait state");
`endif

endmodule

// ===== src/smdv_alu.sv =====
// Shared iterative unit: shift-add multiplier and restoring divider, one bit per cycle.
module smdv_alu #(
  parameter int W = 54
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  smdv_pkg::alu_ctl_t ctl_i,
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  input  logic [$clog2(W+1)-1:0] steps_i,
  output logic [W-1:0]       res_o,
  output smdv_pkg::alu_sts_t sts_o
);

  localparam int CW = $clog2(W + 1);

  smdv_pkg::alu_op_e op_q;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  mcd_q, mcd_d;
  logic [W-1:0]  mpl_q, mpl_d;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          done_q;

  logic          is_div;
  logic [W:0]    add_x;
  logic [W:0]    add_y;
  logic [W+1:0]  add_s;
  logic          ge;

  // One adder serves both ops: add for multiply, trial subtract for divide
  assign is_div = (op_q == smdv_pkg::ALU_DIV);
  assign add_x  = is_div ? {acc_q, mpl_q[W-1]} : {1'b0, acc_q};
  assign add_y  = is_div ? ~{1'b0, mcd_q} : {1'b0, mcd_q};
  assign add_s  = {1'b0, add_x} + {1'b0, add_y} + {{(W+1){1'b0}}, is_div};
  assign ge     = add_s[W+1];

  // Next value of the datapath for one step
  always_comb begin
    acc_d = acc_q;
    mcd_d = mcd_q;
    mpl_d = mpl_q;
    if (is_div) begin
      acc_d = ge ? add_s[W-1:0] : add_x[W-1:0];
      mpl_d = {mpl_q[W-2:0], ge};
    end else begin
      acc_d = mpl_q[0] ? add_s[W-1:0] : acc_q;
      mcd_d = {mcd_q[W-2:0], 1'b0};
      mpl_d = {1'b0, mpl_q[W-1:1]};
    end
  end

  // Load operands on start, step while running
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q <= '0;
      mcd_q <= (ctl_i.op == smdv_pkg::ALU_DIV) ? b_i : a_i;
      mpl_q <= (ctl_i.op == smdv_pkg::ALU_DIV) ? a_i : b_i;
    end else if (run_q) begin
      acc_q <= acc_d;
      mcd_q <= mcd_d;
      mpl_q <= mpl_d;
    end
  end

  // Count steps and flag completion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= smdv_pkg::ALU_MUL;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (ctl_i.start) begin
      op_q   <= ctl_i.op;
      cnt_q  <= steps_i;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (cnt_q == CW'(1));
      if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  assign res_o        = is_div ? mpl_q : acc_q;
  assign sts_o.done   = done_q;
  assign sts_o.rem_nz = |acc_q;

endmodule

// ===== src/smdv_store.sv =====
// Per-dimension sum and sum-of-squares memory with per-entry valid bits.
module smdv_store #(
  parameter int DIMS  = 39,
  parameter int AW    = 6,
  parameter int SUM_W = 27,
  parameter int SQ_W  = 41
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  smdv_pkg::mem_ctl_t      ctl_i,
  input  logic [AW-1:0]           rd_addr_i,
  input  logic [AW-1:0]           wr_addr_i,
  input  logic signed [SUM_W-1:0] wr_sum_i,
  input  logic [SQ_W-1:0]         wr_sq_i,
  output logic signed [SUM_W-1:0] rd_sum_o,
  output logic [SQ_W-1:0]         rd_sq_o
);

  logic signed [SUM_W-1:0] sum_mem [DIMS];
  logic [SQ_W-1:0]         sq_mem  [DIMS];
  logic [DIMS-1:0]         vld_q;
  logic signed [SUM_W-1:0] rd_sum_q;
  logic [SQ_W-1:0]         rd_sq_q;
  logic                    rd_vld_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      sum_mem[wr_addr_i] <= wr_sum_i;
      sq_mem[wr_addr_i]  <= wr_sq_i;
    end
    if (ctl_i.rd_en) begin
      rd_sum_q <= sum_mem[rd_addr_i];
      rd_sq_q  <= sq_mem[rd_addr_i];
    end
  end

  // Track written entries; a clear drops them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        vld_q <= '0;
      end else if (ctl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Unwritten entries read as zero
  assign rd_sum_o = rd_vld_q ? rd_sum_q : '0;
  assign rd_sq_o  = rd_vld_q ? rd_sq_q : '0;

endmodule

// ===== verif/tb.sv =====
// Testbench for the segment mean and diagonal variance block: random frames with self-checking.
`timescale 1ns / 1ps

module tb;

  localparam int DIMS        = smdv_pkg::DIMS_DEF;
  localparam int MAX_FRAMES  = smdv_pkg::MAX_FRAMES_DEF;
  // Longest quiet stretch: it must cover the slowest report beat and the longest sender gap
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 300;
  localparam int ITEM_TARGET = 170;

  // Mode code that the block ignores
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Track per-dimension sums and queue the expected report beats
  class seg_stats_board #(int NDIM = 39, int CAP = 1024);
    localparam int SUM_W = 27;
    localparam int SQ_W  = 41;
    localparam int CNT_W = 11;

    bit signed [SUM_W-1:0]       dim_total [NDIM];
    bit [SQ_W-1:0]               dim_sq_total [NDIM];
    bit [CNT_W-1:0]              frames_in;
    bit [smdv_pkg::DIM_W-1:0]    next_dim;
    bit                          drop_seen;
    smdv_pkg::out_t              expected_beats [$];
    int                          mismatches;

    // Print one line for a mismatch and count it
    task report_mismatch(string msg);
      mismatches++;
      $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    // Apply one accepted command to the segment state
    function void take_command(smdv_pkg::in_t cmd);
      int             pos;
      bit             full;
      longint         v, n, s1, s2, num, mean_q, var_q;
      smdv_pkg::out_t beat;
      v = longint'(cmd.value);
      case (cmd.mode)
        smdv_pkg::MODE_PUSH: begin
          pos = int'(next_dim);
          if (pos >= NDIM) pos = 0;
          full = frames_in >= CAP;
          // Drop the element once the segment is full, but keep the position moving
          if (full) begin
            drop_seen = 1'b1;
          end else begin
            dim_total[pos]    = dim_total[pos] + SUM_W'(v);
            dim_sq_total[pos] = dim_sq_total[pos] + SQ_W'(v * v);
          end
          pos++;
          if (pos >= NDIM) begin
            pos = 0;
            if (!full) frames_in++;
          end
          next_dim = smdv_pkg::DIM_W'(pos);
        end
        smdv_pkg::MODE_REPORT: begin
          n = longint'(frames_in);
          for (int d = 0; d < NDIM; d++) begin
            mean_q = 0;
            var_q  = 0;
            if (n > 0) begin
              s1  = longint'(dim_total[d]);
              s2  = longint'(dim_sq_total[d]);
              num = n * s2 - s1 * s1;
              // Floor the mean, then saturate to the output width
              mean_q = s1 / n;
              if ((s1 % n) != 0 && s1 < 0) mean_q--;
              if (mean_q > smdv_pkg::MEAN_MAX) mean_q = smdv_pkg::MEAN_MAX;
              if (mean_q < -smdv_pkg::MEAN_NEG_MAG) mean_q = -smdv_pkg::MEAN_NEG_MAG;
              // Clamp a negative spread (partial frame) to zero
              if (num > 0) begin
                var_q = num / (n * n);
                if (var_q > smdv_pkg::VAR_MAX) var_q = smdv_pkg::VAR_MAX;
              end
            end
            beat.dimension = smdv_pkg::DIM_W'(d);
            beat.mean      = smdv_pkg::MEAN_W'(mean_q);
            beat.variance  = smdv_pkg::VAR_W'(var_q);
            beat.empty_res = (n == 0);
            beat.dropped   = drop_seen;
            beat.last      = (d == NDIM - 1);
            expected_beats.insert(expected_beats.size(), beat);
          end
        end
        smdv_pkg::MODE_CLEAR: begin
          foreach (dim_total[d]) begin
            dim_total[d]    = '0;
            dim_sq_total[d] = '0;
          end
          frames_in = '0;
          next_dim  = '0;
          drop_seen = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // Compare one result beat with the oldest expected beat
    task check_beat(smdv_pkg::out_t got);
      smdv_pkg::out_t want;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat for dimension %0d", got.dimension));
        return;
      end
      want = expected_beats.pop_front();
      if (got.dimension !== want.dimension)
        report_mismatch($sformatf("dimension got %0d want %0d", got.dimension, want.dimension));
      if (got.mean !== want.mean)
        report_mismatch($sformatf("dim %0d mean got %0d want %0d",
                                  want.dimension, got.mean, want.mean));
      if (got.variance !== want.variance)
        report_mismatch($sformatf("dim %0d variance got %0d want %0d",
                                  want.dimension, got.variance, want.variance));
      if (got.empty_res !== want.empty_res)
        report_mismatch($sformatf("dim %0d empty_res got %b want %b",
                                  want.dimension, got.empty_res, want.empty_res));
      if (got.dropped !== want.dropped)
        report_mismatch($sformatf("dim %0d dropped got %b want %b",
                                  want.dimension, got.dropped, want.dropped));
      if (got.last !== want.last)
        report_mismatch($sformatf("dim %0d last got %b want %b",
                                  want.dimension, got.last, want.last));
    endtask
  endclass

  logic           clk   = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  smdv_pkg::in_t  cmd   = '0;
  logic           busy;
  logic           out_valid;
  smdv_pkg::out_t result;

  seg_stats_board #(DIMS, MAX_FRAMES) board;

  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  segment_mean_diag_variance_top #(
    .DIMS       (DIMS),
    .MAX_FRAMES (MAX_FRAMES)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .in_i        (cmd),
    .busy_o      (busy),
    .out_valid_o (out_valid),
    .out_o       (result)
  );

  // Free-running clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every result beat in the cycle it is shown
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_beat(result);
  end

  // Stop the run when neither side moves a beat for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Hold start low for a number of cycles
  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold start low until every expected beat has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.expected_beats.size() != 0) @(negedge clk);
  endtask

  // Present one command and wait until the block takes it
  task automatic send(logic [1:0] mode, logic signed [smdv_pkg::VALUE_W-1:0] value);
    smdv_pkg::in_t item;
    item.mode  = mode;
    item.value = value;
    if (burst_left == 0) begin
      hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= item;
    do @(posedge clk); while (busy);
    board.take_command(item);
    burst_left--;
    if (mode != MODE_SPARE) items_sent++;
  endtask

  // Pick an element value: full range, pinned extremes, or extremes mixed with small values
  function automatic logic signed [smdv_pkg::VALUE_W-1:0] pick_value(int style);
    case (style)
      1: return 16'sh7FFF;
      2: return 16'sh8000;
      3: begin
        case ($urandom_range(0, 2))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          default: return smdv_pkg::VALUE_W'(int'($urandom_range(0, 15)) - 8);
        endcase
      end
      default: return smdv_pkg::VALUE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Maybe clear, then push whole frames plus a partial tail, with the odd stray command, then report
  task automatic run_segment(int frames_lo, int frames_hi);
    int frames;
    int tail;
    int style;
    style = $urandom_range(0, 5);
    if ($urandom_range(0, 1)) send(smdv_pkg::MODE_CLEAR, pick_value(0));
    frames = $urandom_range(frames_lo, frames_hi);
    tail   = $urandom_range(0, 5);
    for (int i = 0; i < frames * DIMS + tail; i++) begin
      if ($urandom_range(0, 49) == 0)
        send(2'($urandom_range(smdv_pkg::MODE_PUSH, MODE_SPARE)), pick_value(0));
      send(smdv_pkg::MODE_PUSH, pick_value(style));
    end
    if ($urandom_range(0, 2) == 0) drain();
    send(smdv_pkg::MODE_REPORT, pick_value(0));
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Report on the empty segment, then an ignored command
    send(smdv_pkg::MODE_REPORT, 16'sh0000);
    send(MODE_SPARE, 16'sh5A5A);
    // Partial frame of extreme values: still no complete frame, so the report is empty
    send(smdv_pkg::MODE_PUSH, 16'sh7FFF);
    send(smdv_pkg::MODE_PUSH, 16'sh8000);
    send(smdv_pkg::MODE_PUSH, 16'sh0000);
    send(smdv_pkg::MODE_PUSH, 16'shFFFF);
    send(smdv_pkg::MODE_PUSH, 16'sh0001);
    send(smdv_pkg::MODE_REPORT, 16'shFFFF);
    drain();
    // Clear, and clear in the middle of a frame
    send(smdv_pkg::MODE_CLEAR, 16'shA5A5);
    send(smdv_pkg::MODE_REPORT, 16'sh0000);
    send(smdv_pkg::MODE_PUSH, 16'sh1234);
    send(smdv_pkg::MODE_CLEAR, 16'sh0000);
    send(smdv_pkg::MODE_REPORT, 16'sh0000);

    // Two whole frames and a tail of up to five elements once, then short random segments
    run_segment(2, 2);
    while (items_sent < ITEM_TARGET) run_segment(0, 1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/smdv_pkg.sv
src/smdv_alu.sv
src/smdv_store.sv
src/segment_mean_diag_variance_top.sv
verif/tb.sv
